### src/adcar_pkg.sv
// ---------------------------------------------------------------------------
// adcar_pkg
// Types and constants for the auto-ranging converter front end.
// ---------------------------------------------------------------------------
package adcar_pkg;

   localparam int RAW_W    = 12;
   localparam int REF_W    = 11;
   localparam int PADDR_W  = 3;
   localparam int PDATA_W  = 32;

   // result status codes
   typedef enum logic [2:0] {
      ST_CAL_TAKEN = 3'd0,
      ST_CAL_DONE  = 3'd1,
      ST_RETRY     = 3'd2,
      ST_READY     = 3'd3,
      ST_GAVE_UP   = 3'd4
   } status_type;

   // input kinds
   localparam logic REQ_CALIB   = 1'b0;
   localparam logic REQ_MEASURE = 1'b1;

   // gain settings
   typedef enum logic [1:0] {
      GAIN_X1      = 2'd0,
      GAIN_HALF    = 2'd1,
      GAIN_QUARTER = 2'd2
   } gain_type;

   // register index (paddr[2])
   localparam logic REG_IDX_REF_MV = 1'b0;

   localparam logic [REF_W-1:0] REF_MV_RESET = 11'd1050;

   localparam logic [4:0] CALIB_SAMPLES = 5'd16;
   localparam logic [1:0] MAX_TRIES     = 2'd3;

   localparam logic [15:0] OFFSET_MID    = 16'd2048;
   localparam logic [15:0] TH_X1_UP      = 16'd3900;
   localparam logic [15:0] TH_HALF_DOWN  = 16'd2877;
   localparam logic [15:0] TH_HALF_UP    = 16'd3949;
   localparam logic [15:0] TH_QTR_TO_HALF = 16'd2450;
   localparam logic [15:0] TH_QTR_TO_X1  = 16'd2950;
   localparam logic [15:0] BASE_HALF     = 16'd1024;
   localparam logic [15:0] BASE_QTR      = 16'd1536;

   // code = floor(P*R*819 / (8192*165)), P = excess scaled to the x1 base
   localparam logic [28:0] SAT_LIMIT  = 29'd6760051;
   localparam logic [9:0]  MUL_819    = 10'd819;
   localparam logic [20:0] RECIP_165  = 21'd1626882;  // ceil(2^28 / 165)
   localparam logic [11:0] CODE_MAX   = 12'd4095;

endpackage

### src/adcar_channels.sv
// ---------------------------------------------------------------------------
// adcar channels
// Valid/ready channel interfaces for input samples and results.
// ---------------------------------------------------------------------------
interface adcar_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic [11:0] raw_code;

   modport source (output valid, output req_type, output raw_code, input ready);
   modport sink   (input valid, input req_type, input raw_code, output ready);
endinterface

interface adcar_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [1:0]  gain_now;
   logic [11:0] code_out;

   modport source (output valid, output status, output gain_now, output code_out,
                   input ready);
   modport sink   (input valid, input status, input gain_now, input code_out,
                   output ready);
endinterface

### src/adc_autorange_with_offset_calib.sv
// ---------------------------------------------------------------------------
// adc_autorange_with_offset_calib: auto-ranging front end with offset calibration
// Pipeline: an item is registered in s0, s1, s2 and s3 in turn (4-register pipe); s3 drives the result.
// Throughput: one item per cycle while rsp_ch.ready does not stall the pipe.
// Reset: synchronous; clears pipe, offset, calibration, gain, tries; ref = 1050.
// ---------------------------------------------------------------------------
module adc_autorange_with_offset_calib (
   input  logic                            clock,
   input  logic                            reset,
   adcar_req_if.sink                       req_ch,
   adcar_rsp_if.source                     rsp_ch,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [adcar_pkg::PADDR_W-1:0]   csr_paddr,
   input  logic [adcar_pkg::PDATA_W-1:0]   csr_pwdata,
   output logic [adcar_pkg::PDATA_W-1:0]   csr_prdata,
   output logic                            csr_pready
);
   import adcar_pkg::*;

   // config
   logic [REF_W-1:0] ref_mv_ff, ref_mv_in;
   logic             csr_wr;

   // persistent state
   logic [15:0] offset_ff, offset_in;
   logic [15:0] calib_sum_ff, calib_sum_in;
   logic [4:0]  calib_count_ff, calib_count_in;
   gain_type    gain_ff, gain_in;
   logic [1:0]  try_ff, try_in;

   // stage 0: input register
   logic             s0_valid_ff, s0_valid_in;
   logic             s0_type_ff;
   logic [RAW_W-1:0] s0_raw_ff;

   // stage 1: decision + product
   logic        s1_valid_ff, s1_valid_in;
   status_type  s1_status_ff, s1_status_in;
   gain_type    s1_gain_ff;
   logic        s1_val_ff, s1_val_in;
   logic [28:0] s1_prod_ff, s1_prod_in;

   // stage 2: scale by 819 / 8192
   logic        s2_valid_ff, s2_valid_in;
   status_type  s2_status_ff;
   gain_type    s2_gain_ff;
   logic        s2_val_ff;
   logic        s2_sat_ff, s2_sat_in;
   logic [19:0] s2_y_ff, s2_y_in;
   logic [32:0] s2_scaled;

   // stage 3: output register
   logic        s3_valid_ff, s3_valid_in;
   status_type  s3_status_ff;
   gain_type    s3_gain_ff;
   logic [11:0] s3_code_ff, s3_code_in;
   logic [40:0] s3_quot;

   // flow control
   logic req_acc, s0_move, s0_free, s1_move, s1_free, s2_move, s2_free, out_free;

   // stage-0 work
   logic [15:0] sum_acc;
   logic [4:0]  count_acc;
   logic [16:0] mean_sum;
   logic [15:0] offset_cal;
   logic [15:0] meas;
   logic [15:0] diff_half, diff_qtr;
   logic [1:0]  try_inc;
   logic [17:0] excess;
   logic        retry;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready
                   && (csr_paddr[2] == REG_IDX_REF_MV);
   assign ref_mv_in = csr_wr ? csr_pwdata[REF_W-1:0] : ref_mv_ff;

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == REG_IDX_REF_MV) begin
         csr_prdata = {{(PDATA_W-REF_W){1'b0}}, ref_mv_ff};
      end
   end

   // ---------------- flow control ----------------
   assign out_free = !s3_valid_ff || rsp_ch.ready;
   assign s2_move  = s2_valid_ff && out_free;
   assign s2_free  = !s2_valid_ff || out_free;
   assign s1_move  = s1_valid_ff && s2_free;
   assign s1_free  = !s1_valid_ff || s2_free;
   assign s0_move  = s0_valid_ff && s1_free;
   assign s0_free  = !s0_valid_ff || s1_free;

   assign req_ch.ready = s0_free;
   assign req_acc      = req_ch.valid && s0_free;

   assign s0_valid_in = req_acc ? 1'b1 : (s0_move ? 1'b0 : s0_valid_ff);
   assign s1_valid_in = s0_move ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);
   assign s2_valid_in = s1_move ? 1'b1 : (s2_move ? 1'b0 : s2_valid_ff);
   assign s3_valid_in = s2_move ? 1'b1 : ((s3_valid_ff && rsp_ch.ready) ? 1'b0 : s3_valid_ff);

   // ---------------- stage 0: decision and state update ----------------
   always_comb begin
      sum_acc    = calib_sum_ff + {4'b0000, ~s0_raw_ff};
      count_acc  = calib_count_ff + 5'd1;
      mean_sum   = {1'b0, sum_acc} + 17'd8;
      offset_cal = OFFSET_MID - {3'b000, mean_sum[16:4]};
      meas       = {4'b0000, s0_raw_ff} + offset_ff;
      diff_half  = meas - BASE_HALF;
      diff_qtr   = meas - BASE_QTR;
      try_inc    = try_ff + 2'd1;

      offset_in      = offset_ff;
      calib_sum_in   = calib_sum_ff;
      calib_count_in = calib_count_ff;
      gain_in        = gain_ff;
      try_in         = try_ff;
      s1_status_in   = ST_CAL_TAKEN;
      s1_val_in      = 1'b0;
      excess         = '0;
      retry          = 1'b1;

      if (s0_type_ff == REQ_CALIB) begin
         calib_sum_in   = sum_acc;
         calib_count_in = count_acc;
         if (count_acc >= CALIB_SAMPLES) begin
            offset_in      = offset_cal;
            calib_sum_in   = '0;
            calib_count_in = '0;
            s1_status_in   = ST_CAL_DONE;
         end
      end else begin
         case (gain_ff)
            GAIN_X1: begin
               if (meas > TH_X1_UP) begin
                  gain_in = GAIN_HALF;
               end else begin
                  retry  = 1'b0;
                  excess = {2'b00, meas};
               end
            end
            GAIN_HALF: begin
               if (meas < TH_HALF_DOWN) begin
                  gain_in = GAIN_X1;
               end else if (meas > TH_HALF_UP) begin
                  gain_in = GAIN_QUARTER;
               end else begin
                  retry  = 1'b0;
                  excess = {1'b0, diff_half, 1'b0};
               end
            end
            GAIN_QUARTER: begin
               if (meas < TH_QTR_TO_HALF) begin
                  gain_in = GAIN_HALF;
               end else if (meas < TH_QTR_TO_X1) begin
                  gain_in = GAIN_X1;
               end else begin
                  retry  = 1'b0;
                  excess = {diff_qtr, 2'b00};
               end
            end
            default: begin
               gain_in = GAIN_X1;
            end
         endcase

         if (retry) begin
            if (try_inc >= MAX_TRIES) begin
               s1_status_in = ST_GAVE_UP;
               try_in       = '0;
            end else begin
               s1_status_in = ST_RETRY;
               try_in       = try_inc;
            end
         end else begin
            s1_status_in = ST_READY;
            s1_val_in    = 1'b1;
            try_in       = '0;
         end
      end
   end

   assign s1_prod_in = {11'b0, excess} * {18'b0, ref_mv_ff};

   // ---------------- stage 1 -> 2: clamp check, scale by 819 ----------------
   assign s2_sat_in = (s1_prod_ff >= SAT_LIMIT);
   assign s2_scaled = {10'b0, s1_prod_ff[22:0]} * {23'b0, MUL_819};
   assign s2_y_in   = s2_scaled[32:13];

   // ---------------- stage 2 -> 3: divide by 165 via reciprocal ----------------
   assign s3_quot = {21'b0, s2_y_ff} * {20'b0, RECIP_165};

   always_comb begin
      if (!s2_val_ff) begin
         s3_code_in = '0;
      end else if (s2_sat_ff) begin
         s3_code_in = CODE_MAX;
      end else begin
         s3_code_in = s3_quot[39:28];
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         ref_mv_ff      <= REF_MV_RESET;
         offset_ff      <= '0;
         calib_sum_ff   <= '0;
         calib_count_ff <= '0;
         gain_ff        <= GAIN_X1;
         try_ff         <= '0;
         s0_valid_ff    <= 1'b0;
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
         s3_valid_ff    <= 1'b0;
      end else begin
         ref_mv_ff   <= ref_mv_in;
         s0_valid_ff <= s0_valid_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
         if (s0_move) begin
            offset_ff      <= offset_in;
            calib_sum_ff   <= calib_sum_in;
            calib_count_ff <= calib_count_in;
            gain_ff        <= gain_in;
            try_ff         <= try_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s0_type_ff <= req_ch.req_type;
         s0_raw_ff  <= req_ch.raw_code;
      end
      if (s0_move) begin
         s1_status_ff <= s1_status_in;
         s1_gain_ff   <= gain_in;
         s1_val_ff    <= s1_val_in;
         s1_prod_ff   <= s1_prod_in;
      end
      if (s1_move) begin
         s2_status_ff <= s1_status_ff;
         s2_gain_ff   <= s1_gain_ff;
         s2_val_ff    <= s1_val_ff;
         s2_sat_ff    <= s2_sat_in;
         s2_y_ff      <= s2_y_in;
      end
      if (s2_move) begin
         s3_status_ff <= s2_status_ff;
         s3_gain_ff   <= s2_gain_ff;
         s3_code_ff   <= s3_code_in;
      end
   end

   assign rsp_ch.valid    = s3_valid_ff;
   assign rsp_ch.status   = s3_status_ff;
   assign rsp_ch.gain_now = s3_gain_ff;
   assign rsp_ch.code_out = s3_code_ff;

endmodule

### tb/testbench.sv
// ---------------------------------------------------------------------------
// testbench: auto-ranging front end with offset calibration
// Drives calibration and measurement samples through the valid/ready
// channels, writes the reference voltage over the APB port between phases,
// and checks every result in order against a local predictor of offset,
// gain stepping, retry counting and code scaling.
// ---------------------------------------------------------------------------
module testbench;
   import adcar_pkg::*;

   localparam int PHASES       = 8;
   localparam int PHASE_ITEMS  = 210;
   localparam int HOLD_CYCLES  = 80;
   localparam int FILL_ITEMS   = 40;
   localparam int DRAIN_CYCLES = 12;
   localparam int CYCLE_LIMIT  = 600000;
   localparam int NUM_ROWS     = 25;

   typedef struct packed {
      status_type  status;
      logic [1:0]  gain;
      logic [11:0] code;
   } outcome_t;

   typedef struct packed {
      logic        kind;
      logic [11:0] raw;
      logic [4:0]  reps;
      logic        pinned;
      status_type  status;
      gain_type    gain;
      logic [11:0] code;
   } stim_row_t;

   // directed walk: gain ladder up and down, thresholds, give-up, calibration
   // extremes and offset wrap; pinned rows carry their expected result
   stim_row_t dir_rows [NUM_ROWS] = '{
      '{REQ_MEASURE, 12'd0,    5'd1,  1'b1, ST_READY,     GAIN_X1,      12'd0},
      '{REQ_MEASURE, 12'd4095, 5'd1,  1'b1, ST_RETRY,     GAIN_HALF,    12'd0},
      '{REQ_MEASURE, 12'd4095, 5'd1,  1'b1, ST_RETRY,     GAIN_QUARTER, 12'd0},
      '{REQ_MEASURE, 12'd4095, 5'd1,  1'b1, ST_READY,     GAIN_QUARTER, 12'd4095},
      '{REQ_MEASURE, 12'd2950, 5'd1,  1'b0, ST_CAL_TAKEN, GAIN_X1,      12'd0},
      '{REQ_MEASURE, 12'd2949, 5'd1,  1'b1, ST_RETRY,     GAIN_X1,      12'd0},
      '{REQ_MEASURE, 12'd3900, 5'd1,  1'b0, ST_CAL_TAKEN, GAIN_X1,      12'd0},
      '{REQ_MEASURE, 12'd3901, 5'd1,  1'b1, ST_RETRY,     GAIN_HALF,    12'd0},
      '{REQ_MEASURE, 12'd3949, 5'd1,  1'b0, ST_CAL_TAKEN, GAIN_X1,      12'd0},
      '{REQ_MEASURE, 12'd2877, 5'd1,  1'b0, ST_CAL_TAKEN, GAIN_X1,      12'd0},
      '{REQ_MEASURE, 12'd2876, 5'd1,  1'b1, ST_RETRY,     GAIN_X1,      12'd0},
      '{REQ_MEASURE, 12'd3901, 5'd1,  1'b1, ST_RETRY,     GAIN_HALF,    12'd0},
      '{REQ_MEASURE, 12'd3950, 5'd1,  1'b1, ST_GAVE_UP,   GAIN_QUARTER, 12'd0},
      '{REQ_MEASURE, 12'd2449, 5'd1,  1'b1, ST_RETRY,     GAIN_HALF,    12'd0},
      '{REQ_MEASURE, 12'd3950, 5'd1,  1'b1, ST_RETRY,     GAIN_QUARTER, 12'd0},
      '{REQ_MEASURE, 12'd2450, 5'd1,  1'b1, ST_GAVE_UP,   GAIN_X1,      12'd0},
      '{REQ_CALIB,   12'd4095, 5'd15, 1'b1, ST_CAL_TAKEN, GAIN_X1,      12'd0},
      '{REQ_CALIB,   12'd4095, 5'd1,  1'b1, ST_CAL_DONE,  GAIN_X1,      12'd0},
      '{REQ_MEASURE, 12'd4095, 5'd1,  1'b1, ST_RETRY,     GAIN_HALF,    12'd0},
      '{REQ_MEASURE, 12'd0,    5'd1,  1'b1, ST_RETRY,     GAIN_X1,      12'd0},
      '{REQ_CALIB,   12'd0,    5'd16, 1'b0, ST_CAL_TAKEN, GAIN_X1,      12'd0},
      '{REQ_MEASURE, 12'd4095, 5'd1,  1'b0, ST_CAL_TAKEN, GAIN_X1,      12'd0},
      '{REQ_MEASURE, 12'd0,    5'd1,  1'b0, ST_CAL_TAKEN, GAIN_X1,      12'd0},
      '{REQ_CALIB,   12'd2048, 5'd16, 1'b0, ST_CAL_TAKEN, GAIN_X1,      12'd0},
      '{REQ_MEASURE, 12'd2048, 5'd1,  1'b0, ST_CAL_TAKEN, GAIN_X1,      12'd0}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   adcar_req_if req_bus ();
   adcar_rsp_if rsp_bus ();

   adc_autorange_with_offset_calib i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_bus),
      .rsp_ch      (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic [10:0] ref_mv     = REF_MV_RESET;
   logic [15:0] zero_shift = '0;
   logic [15:0] cal_acc    = '0;
   logic [4:0]  cal_seen   = '0;
   logic [1:0]  gain_pos   = GAIN_X1;
   logic [1:0]  retries    = '0;

   outcome_t outcome_q [$];
   int       mismatch_count = 0;
   int       cycle_count    = 0;
   bit       calm           = 1'b0;
   bit       hold_req       = 1'b0;

   function automatic void note_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 10) $display("mismatch: %s", what);
   endfunction

   function automatic int idle_length();
      int unsigned pick;
      if (calm) return 0;
      pick = $urandom_range(0, 99);
      if (pick < 60) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      if (pick < 98) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // floor(excess * R * 4095 / (base * 3300)), saturated to 12 bits
   function automatic logic [11:0] volts_to_code(input logic [15:0] excess,
                                                 input int unsigned base);
      longint unsigned q;
      q = (64'(excess) * 64'(ref_mv) * 64'd4095) / (64'(base) * 64'd3300);
      return (q > 64'd4095) ? CODE_MAX : q[11:0];
   endfunction

   function automatic outcome_t range_and_scale(input logic kind, input logic [11:0] raw);
      outcome_t    res;
      logic [15:0] level;
      logic [16:0] rounded;
      bit          got_code;
      res.status = ST_CAL_TAKEN;
      res.code   = '0;
      got_code   = 1'b0;
      if (kind == REQ_CALIB) begin
         cal_acc  = cal_acc + {4'd0, ~raw};
         cal_seen = cal_seen + 5'd1;
         if (cal_seen >= CALIB_SAMPLES) begin
            rounded    = ({1'b0, cal_acc} + 17'd8) >> 4;
            zero_shift = OFFSET_MID - rounded[15:0];
            cal_acc    = '0;
            cal_seen   = '0;
            res.status = ST_CAL_DONE;
         end
      end else begin
         level = {4'd0, raw} + zero_shift;
         case (gain_pos)
            GAIN_X1: begin
               if (level > TH_X1_UP) gain_pos = GAIN_HALF;
               else begin
                  res.code = volts_to_code(level, 2048);
                  got_code = 1'b1;
               end
            end
            GAIN_HALF: begin
               if (level < TH_HALF_DOWN) gain_pos = GAIN_X1;
               else if (level > TH_HALF_UP) gain_pos = GAIN_QUARTER;
               else begin
                  res.code = volts_to_code(level - BASE_HALF, 1024);
                  got_code = 1'b1;
               end
            end
            GAIN_QUARTER: begin
               if (level < TH_QTR_TO_HALF) gain_pos = GAIN_HALF;
               else if (level < TH_QTR_TO_X1) gain_pos = GAIN_X1;
               else begin
                  res.code = volts_to_code(level - BASE_QTR, 512);
                  got_code = 1'b1;
               end
            end
            default: gain_pos = GAIN_X1;
         endcase
         if (got_code) begin
            res.status = ST_READY;
            retries    = '0;
         end else begin
            retries = retries + 2'd1;
            if (retries >= MAX_TRIES) begin
               res.status = ST_GAVE_UP;
               retries    = '0;
            end else begin
               res.status = ST_RETRY;
            end
         end
      end
      res.gain = gain_pos;
      return res;
   endfunction

   // mostly aims the corrected level at a threshold or a valid window
   function automatic logic [11:0] pick_measure_raw();
      int unsigned pick;
      int          target;
      logic [15:0] need;
      pick = $urandom_range(0, 99);
      if (pick < 10) return ($urandom_range(0, 1) != 0) ? 12'd4095 : 12'd0;
      if (pick < 35) return 12'($urandom_range(0, 4095));
      if (pick < 75) begin
         case ($urandom_range(0, 4))
            0: target = int'(TH_X1_UP);
            1: target = int'(TH_HALF_DOWN);
            2: target = int'(TH_HALF_UP);
            3: target = int'(TH_QTR_TO_HALF);
            default: target = int'(TH_QTR_TO_X1);
         endcase
         target = target + int'($urandom_range(0, 6)) - 3;
      end else begin
         target = $urandom_range(0, 6000);
      end
      need = 16'(target) - zero_shift;
      if (need > 16'd4095) return 12'($urandom_range(0, 4095));
      return need[11:0];
   endfunction

   // ready is sampled at the falling edge, where it holds its pre-edge value
   task automatic offer_item(input logic kind, input logic [11:0] raw,
                             input bit use_pinned, input outcome_t pinned);
      outcome_t predicted;
      int       gap;
      bit       took;
      req_bus.valid    <= 1'b1;
      req_bus.req_type <= kind;
      req_bus.raw_code <= raw;
      took = 1'b0;
      while (!took) begin
         @(negedge clock);
         took = req_bus.ready;
         @(posedge clock);
      end
      predicted = range_and_scale(kind, raw);
      outcome_q.push_back(use_pinned ? pinned : predicted);
      gap = idle_length();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic csr_access(input logic wr, input logic [31:0] wdata,
                             output logic [31:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {REG_IDX_REF_MV, 2'b00};
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   initial begin : run_limit
      while (cycle_count < CYCLE_LIMIT) @(posedge clock) cycle_count++;
      $display("testbench: FAIL");
      $finish;
   end

   initial begin : result_sink
      int       stall_left;
      outcome_t want;
      outcome_t got;
      bit       fire;
      stall_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         // handshake and payload are stable between the falling and rising edge
         @(negedge clock);
         fire = !reset && rsp_bus.valid && rsp_bus.ready;
         got  = {rsp_bus.status, rsp_bus.gain_now, rsp_bus.code_out};
         @(posedge clock);
         if (fire) begin
            if (outcome_q.size() == 0) begin
               note_mismatch($sformatf("unexpected item: status %0d gain %0d code %0d",
                                       got.status, got.gain, got.code));
            end else begin
               want = outcome_q.pop_front();
               if (got.status !== want.status || got.gain !== want.gain ||
                   got.code !== want.code)
                  note_mismatch($sformatf({"status %0d/%0d gain %0d/%0d code %0d/%0d",
                                           " (expected/actual)"},
                                          want.status, got.status, want.gain,
                                          got.gain, want.code, got.code));
            end
         end
         if (hold_req) begin
            stall_left = HOLD_CYCLES;
            hold_req   = 1'b0;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            stall_left = idle_length();
            if (stall_left == 0) begin
               rsp_bus.ready <= 1'b1;
            end else begin
               stall_left--;
               rsp_bus.ready <= 1'b0;
            end
         end
      end
   end

   initial begin : stimulus
      int          sent;
      int          run_len;
      int          center;
      int          spread;
      int          level;
      logic [10:0] new_ref;
      logic [31:0] rd;
      logic [11:0] cal_raw;
      outcome_t    pinned;
      stim_row_t   row;

      req_bus.valid    <= 1'b0;
      req_bus.req_type <= REQ_CALIB;
      req_bus.raw_code <= '0;
      csr_psel         <= 1'b0;
      csr_penable      <= 1'b0;
      csr_pwrite       <= 1'b0;
      csr_paddr        <= '0;
      csr_pwdata       <= '0;
      pinned           = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < NUM_ROWS; r++) begin
         row           = dir_rows[r];
         pinned.status = row.status;
         pinned.gain   = row.gain;
         pinned.code   = row.code;
         repeat (row.reps) offer_item(row.kind, row.raw, row.pinned, pinned);
      end

      for (int ph = 0; ph < PHASES; ph++) begin
         req_bus.valid <= 1'b0;
         while (outcome_q.size() != 0) @(posedge clock);
         case (ph)
            0: new_ref = 11'd900;
            1: new_ref = 11'd1300;
            2: new_ref = 11'd1023;
            3: new_ref = 11'd1024;
            default: new_ref = 11'($urandom_range(900, 1300));
         endcase
         csr_access(1'b1, {21'd0, new_ref}, rd);
         ref_mv = new_ref;
         csr_access(1'b0, '0, rd);
         if (rd[REF_W-1:0] !== ref_mv)
            note_mismatch($sformatf("ref readback %0d/%0d (expected/actual)",
                                    ref_mv, rd[REF_W-1:0]));

         // phase 2 runs without idling; phase 3 starts with a long sink hold
         calm = (ph == 2) || (ph == 3);
         if (ph == 3) hold_req = 1'b1;
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            if (ph == 3 && sent >= FILL_ITEMS) calm = 1'b0;
            if ($urandom_range(0, 99) < 8) begin
               run_len = ($urandom_range(0, 9) < 8) ? 16 : $urandom_range(1, 15);
               center  = ($urandom_range(0, 9) < 7) ? $urandom_range(1900, 2200)
                                                     : $urandom_range(0, 4095);
               spread  = $urandom_range(0, 24);
               for (int k = 0; k < run_len; k++) begin
                  if ($urandom_range(0, 19) == 0) begin
                     offer_item(REQ_MEASURE, pick_measure_raw(), 1'b0, pinned);
                     sent++;
                  end
                  level = center + int'($urandom_range(0, 2 * spread)) - spread;
                  if (level < 0) level = 0;
                  if (level > 4095) level = 4095;
                  cal_raw = 12'(level);
                  offer_item(REQ_CALIB, cal_raw, 1'b0, pinned);
                  sent++;
               end
            end else begin
               offer_item(REQ_MEASURE, pick_measure_raw(), 1'b0, pinned);
               sent++;
            end
         end
      end

      req_bus.valid <= 1'b0;
      while (outcome_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end

endmodule
